// ===== rtl/cadc_pkg.sv =====
// shared types and constants for the calorimeter adc calibration block
package cadc_pkg;

	// fixed field widths
	localparam int OP_W     = 2;
	localparam int MOD_W    = 8;
	localparam int ETA_W    = 8;
	localparam int SUB_W    = 4;
	localparam int SIM_W    = 24;
	localparam int PED_W    = 16;
	localparam int SLOPE_W  = 24;
	localparam int ENERGY_W = 25;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 16;
	localparam int SUM_W    = 40;
	localparam int ES_W     = 12;
	localparam int CHF_W    = 21;
	localparam int FRAC_SH  = 14;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;

	// opcodes
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_HIT   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_CAL   = 3'd0;
	localparam logic [STATUS_W-1:0] ST_CLAMP = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD   = 3'd2;
	localparam logic [STATUS_W-1:0] ST_SIM   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_SKIP  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_RANGE = 3'd5;
	localparam logic [STATUS_W-1:0] ST_DONE  = 3'd6;

	// energy source select
	localparam logic [1:0] ESEL_ZERO = 2'd0;
	localparam logic [1:0] ESEL_SIM  = 2'd1;
	localparam logic [1:0] ESEL_NEG1 = 2'd2;
	localparam logic [1:0] ESEL_QUOT = 2'd3;

	// register indexes and reset values
	localparam logic [1:0] REG_NUM_MODULES = 2'd0;
	localparam logic [1:0] REG_NUM_ETA     = 2'd1;
	localparam logic [1:0] REG_NUM_SUB     = 2'd2;
	localparam logic [1:0] REG_CALIB       = 2'd3;

	localparam logic [MOD_W-1:0] RST_NUM_MODULES = 8'd120;
	localparam logic [ETA_W-1:0] RST_NUM_ETA     = 8'd20;
	localparam logic [SUB_W-1:0] RST_NUM_SUB     = 4'd2;

	localparam logic [SLOPE_W-1:0] ENERGY_MAX = 24'hFFFFFF;

	// pending result descriptor
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [1:0]          esel;
		logic                ch_zero;
		logic                acc;
		logic                clr;
	} cadc_res_t;

	// controller to datapath
	typedef struct packed {
		logic      latch;
		logic      map1;
		logic      map2;
		logic      mem_wr;
		logic      mem_rd;
		logic      div_start;
		logic      res_set;
		logic      commit;
		cadc_res_t res;
	} cadc_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            range_ok;
		logic            ch_ok;
		logic            adc_neg;
		logic            sim_nz;
		logic            slope_zero;
		logic            num_pos;
		logic            div_done;
		logic            q_zero;
		logic            out_free;
	} cadc_stat_t;

endpackage

// ===== rtl/cadc_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module cadc_div #(
	parameter int DVD_W = 30,
	parameter int DVS_W = 24
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);
	localparam int CW = $clog2(DVD_W + 1);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	// trial subtract of the shifted remainder
	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			run_q  <= 1'b1;
			cnt_q  <= CW'(DVD_W);
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// remainder and quotient shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/cadc_dp.sv =====
// datapath: item registers, channel map, calibration store, divider, totals, result register
module cadc_dp #(
	parameter int MAX_CHANNELS = 32768,
	parameter int ADC_BITS     = 12,
	parameter int CH_W         = $clog2(MAX_CHANNELS)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cadc_pkg::cadc_cmd_t                   cmd,
	output cadc_pkg::cadc_stat_t                  stat,
	input  logic [cadc_pkg::MOD_W-1:0]            num_modules,
	input  logic [cadc_pkg::ETA_W-1:0]            num_eta,
	input  logic [cadc_pkg::SUB_W-1:0]            num_sub,
	input  logic [cadc_pkg::OP_W-1:0]             opcode,
	input  logic [cadc_pkg::MOD_W-1:0]            module_req,
	input  logic [cadc_pkg::ETA_W-1:0]            eta_bin,
	input  logic [cadc_pkg::SUB_W-1:0]            sub_bin,
	input  logic signed [ADC_BITS:0]              adc,
	input  logic [cadc_pkg::SIM_W-1:0]            sim_energy,
	input  logic [cadc_pkg::PED_W-1:0]            pedestal,
	input  logic [cadc_pkg::SLOPE_W-1:0]          slope,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [CH_W-1:0]                       channel,
	output logic signed [cadc_pkg::ENERGY_W-1:0]  energy,
	output logic [cadc_pkg::STATUS_W-1:0]         status,
	output logic [cadc_pkg::CNT_W-1:0]            hit_count,
	output logic [cadc_pkg::SUM_W-1:0]            energy_total
);
	import cadc_pkg::*;

	localparam int MEM_W = PED_W + SLOPE_W;
	localparam int NUM_W = ((ADC_BITS + 5 > PED_W + 1) ? ADC_BITS + 5 : PED_W + 1) + 1;
	localparam int MAG_W = ADC_BITS + 4;
	localparam int DVD_W = MAG_W + FRAC_SH;

	// item registers
	logic [OP_W-1:0]    op_q;
	logic [MOD_W-1:0]   m_q;
	logic [ETA_W-1:0]   e_q;
	logic [SUB_W-1:0]   s_q;
	logic [ADC_BITS:0]  adc_q;
	logic [SIM_W-1:0]   sim_q;
	logic [PED_W-1:0]   ped_in_q;
	logic [SLOPE_W-1:0] slope_in_q;

	// channel map
	logic [ES_W-1:0]  es_q;
	logic [ES_W-1:0]  eoff_q;
	logic             range_ok_q;
	logic [CHF_W-1:0] ch_full_q;
	logic [CH_W-1:0]  ch_idx;

	// calibration store
	logic [MEM_W-1:0] mem [MAX_CHANNELS];
	logic [MEM_W-1:0] rd_q;
	logic [PED_W-1:0]   rd_ped;
	logic [SLOPE_W-1:0] rd_slope;

	// numerator and divider
	logic signed [NUM_W-1:0] num_s;
	logic [DVD_W-1:0]        dividend;
	logic [DVD_W-1:0]        quotient;
	logic                    div_done;
	logic [SLOPE_W-1:0]      q_sat;

	// pending result
	cadc_res_t                  res_q;
	logic [CH_W-1:0]            res_ch_q;
	logic [ENERGY_W-1:0]        res_energy_q;
	logic [ENERGY_W-1:0]        energy_sel;

	// totals and output register
	logic [CNT_W-1:0]  hits_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  hits_nxt;
	logic [SUM_W-1:0]  sum_nxt;
	logic [SUM_W:0]    sum_add;
	logic              out_valid_q;
	logic [CH_W-1:0]   out_ch_q;
	logic [ENERGY_W-1:0] out_energy_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [CNT_W-1:0]  out_hits_q;
	logic [SUM_W-1:0]  out_sum_q;

	// capture the input beat
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q       <= opcode;
			m_q        <= module_req;
			e_q        <= eta_bin;
			s_q        <= sub_bin;
			adc_q      <= adc;
			sim_q      <= sim_energy;
			ped_in_q   <= pedestal;
			slope_in_q <= slope;
		end
	end

	// channel map, first step: bin products and range check
	always_ff @(posedge clk) begin
		if (cmd.map1) begin
			es_q       <= ES_W'(num_eta) * ES_W'(num_sub);
			eoff_q     <= ES_W'(e_q - 8'd1) * ES_W'(num_sub);
			range_ok_q <= (m_q != '0) && (m_q <= num_modules) &&
				(e_q != '0) && (e_q <= num_eta) &&
				(s_q != '0) && (s_q <= num_sub);
		end
	end

	// channel map, second step: module offset and sum
	always_ff @(posedge clk) begin
		if (cmd.map2) begin
			ch_full_q <= CHF_W'(m_q - 8'd1) * CHF_W'(es_q) + CHF_W'(eoff_q) +
				CHF_W'(s_q - 4'd1);
		end
	end

	assign ch_idx = ch_full_q[CH_W-1:0];

	// calibration store, one port, registered read
	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			mem[ch_idx] <= {ped_in_q, slope_in_q};
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[ch_idx];
		end
	end

	assign rd_ped   = rd_q[MEM_W-1:SLOPE_W];
	assign rd_slope = rd_q[SLOPE_W-1:0];

	// numerator: 16*adc - pedestal
	assign num_s = $signed({{(NUM_W-ADC_BITS-5){adc_q[ADC_BITS]}}, adc_q, 4'b0}) -
		$signed({{(NUM_W-PED_W){1'b0}}, rd_ped});
	assign dividend = {num_s[MAG_W-1:0], {FRAC_SH{1'b0}}};

	cadc_div #(
		.DVD_W(DVD_W),
		.DVS_W(SLOPE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (rd_slope),
		.done     (div_done),
		.quotient (quotient)
	);

	// saturate quotient to the energy range
	assign q_sat = (|quotient[DVD_W-1:SLOPE_W]) ? ENERGY_MAX : quotient[SLOPE_W-1:0];

	// energy source select
	always_comb begin
		case (cmd.res.esel)
			ESEL_SIM:  energy_sel = {1'b0, sim_q};
			ESEL_NEG1: energy_sel = '1;
			ESEL_QUOT: energy_sel = {1'b0, q_sat};
			default:   energy_sel = '0;
		endcase
	end

	// hold the pending result
	always_ff @(posedge clk) begin
		if (cmd.res_set) begin
			res_q        <= cmd.res;
			res_ch_q     <= cmd.res.ch_zero ? '0 : ch_idx;
			res_energy_q <= energy_sel;
		end
	end

	// next totals
	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(res_energy_q[SLOPE_W-1:0]);
	always_comb begin
		hits_nxt = hits_q;
		sum_nxt  = sum_q;
		if (res_q.clr) begin
			hits_nxt = '0;
			sum_nxt  = '0;
		end else if (res_q.acc) begin
			if (hits_q != '1) begin
				hits_nxt = hits_q + 1'b1;
			end
			sum_nxt = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
		end
	end

	// totals and result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hits_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			hits_q      <= hits_nxt;
			sum_q       <= sum_nxt;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result beat payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_ch_q     <= res_ch_q;
			out_energy_q <= res_energy_q;
			out_status_q <= res_q.status;
			out_hits_q   <= hits_nxt;
			out_sum_q    <= sum_nxt;
		end
	end

	// status to the controller
	assign stat.op         = op_q;
	assign stat.range_ok   = range_ok_q;
	assign stat.ch_ok      = ch_full_q < CHF_W'(MAX_CHANNELS);
	assign stat.adc_neg    = adc_q[ADC_BITS];
	assign stat.sim_nz     = sim_q != '0;
	assign stat.slope_zero = rd_slope == '0;
	assign stat.num_pos    = !num_s[NUM_W-1] && (num_s != '0);
	assign stat.div_done   = div_done;
	assign stat.q_zero     = quotient == '0;
	assign stat.out_free   = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign channel      = out_ch_q;
	assign energy       = $signed(out_energy_q);
	assign status       = out_status_q;
	assign hit_count    = out_hits_q;
	assign energy_total = out_sum_q;

endmodule

// ===== rtl/cadc_ctrl.sv =====
// controller: sequences one item through map, store access, divide and commit
module cadc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 calib_present,
	input  cadc_pkg::cadc_stat_t stat,
	output cadc_pkg::cadc_cmd_t  cmd
);
	import cadc_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_MAP1   = 4'd1;
	localparam logic [3:0] S_MAP2   = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_READ   = 4'd4;
	localparam logic [3:0] S_CHECK  = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_FIN    = 4'd7;
	localparam logic [3:0] S_COMMIT = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	assign in_ready = state_q == S_IDLE;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = S_MAP1;
				end
			end
			S_MAP1: begin
				cmd.map1  = 1'b1;
				state_nxt = S_MAP2;
			end
			S_MAP2: begin
				cmd.map2  = 1'b1;
				state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.res_set = 1'b1;
				state_nxt   = S_COMMIT;
				if (stat.op == OP_CLEAR) begin
					cmd.res = '{status: ST_DONE, esel: ESEL_ZERO, ch_zero: 1'b1,
						acc: 1'b0, clr: 1'b1};
				end else if ((stat.op != OP_LOAD && stat.op != OP_HIT) ||
					!stat.range_ok || !stat.ch_ok) begin
					cmd.res = '{status: ST_RANGE, esel: ESEL_ZERO, ch_zero: 1'b1,
						acc: 1'b0, clr: 1'b0};
				end else if (stat.op == OP_LOAD) begin
					cmd.mem_wr = 1'b1;
					cmd.res = '{status: ST_DONE, esel: ESEL_ZERO, ch_zero: 1'b0,
						acc: 1'b0, clr: 1'b0};
				end else if (!calib_present) begin
					if (stat.sim_nz) begin
						cmd.res = '{status: ST_SIM, esel: ESEL_SIM, ch_zero: 1'b0,
							acc: 1'b1, clr: 1'b0};
					end else begin
						cmd.res = '{status: ST_SKIP, esel: ESEL_ZERO, ch_zero: 1'b0,
							acc: 1'b0, clr: 1'b0};
					end
				end else if (stat.adc_neg) begin
					cmd.res = '{status: ST_SIM, esel: ESEL_SIM, ch_zero: 1'b0,
						acc: 1'b1, clr: 1'b0};
				end else begin
					cmd.res_set = 1'b0;
					cmd.mem_rd  = 1'b1;
					state_nxt   = S_READ;
				end
			end
			S_READ: begin
				state_nxt = S_CHECK;
			end
			S_CHECK: begin
				if (stat.slope_zero) begin
					cmd.res_set = 1'b1;
					cmd.res = '{status: ST_BAD, esel: ESEL_NEG1, ch_zero: 1'b0,
						acc: 1'b0, clr: 1'b0};
					state_nxt = S_COMMIT;
				end else if (!stat.num_pos) begin
					cmd.res_set = 1'b1;
					cmd.res = '{status: ST_CLAMP, esel: ESEL_ZERO, ch_zero: 1'b0,
						acc: 1'b0, clr: 1'b0};
					state_nxt = S_COMMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = S_DIV;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				cmd.res_set = 1'b1;
				if (stat.q_zero) begin
					cmd.res = '{status: ST_CLAMP, esel: ESEL_ZERO, ch_zero: 1'b0,
						acc: 1'b0, clr: 1'b0};
				end else begin
					cmd.res = '{status: ST_CAL, esel: ESEL_QUOT, ch_zero: 1'b0,
						acc: 1'b1, clr: 1'b0};
				end
				state_nxt = S_COMMIT;
			end
			S_COMMIT: begin
				// wait for the result register to free up
				if (stat.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/calorimeter_adc_calibration.sv =====
// top level: configuration registers, controller and datapath of the adc calibration block
// one item at a time: every item passes latch, map1, map2 and decide; load, clear, out-of-range,
// skipped and simulated hits then commit, a bad slope or non-positive numerator commits after the
// store read and check, and a divided hit also waits for the restoring divider before its commit;
// the next input beat is taken once the item is committed, while that result still waits for its
// output beat. reset clears totals, control and config
module calorimeter_adc_calibration #(
	parameter int MAX_CHANNELS = 32768,
	parameter int ADC_BITS     = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [cadc_pkg::PADDR_W-1:0]          paddr,
	input  logic [cadc_pkg::PDATA_W-1:0]          pwdata,
	output logic [cadc_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [cadc_pkg::OP_W-1:0]             opcode,
	input  logic [cadc_pkg::MOD_W-1:0]            module_req,
	input  logic [cadc_pkg::ETA_W-1:0]            eta_bin,
	input  logic [cadc_pkg::SUB_W-1:0]            sub_bin,
	input  logic signed [ADC_BITS:0]              adc,
	input  logic [cadc_pkg::SIM_W-1:0]            sim_energy,
	input  logic [cadc_pkg::PED_W-1:0]            pedestal,
	input  logic [cadc_pkg::SLOPE_W-1:0]          slope,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [$clog2(MAX_CHANNELS)-1:0]       channel,
	output logic signed [cadc_pkg::ENERGY_W-1:0]  energy,
	output logic [cadc_pkg::STATUS_W-1:0]         status,
	output logic [cadc_pkg::CNT_W-1:0]            hit_count,
	output logic [cadc_pkg::SUM_W-1:0]            energy_total
);
	import cadc_pkg::*;

	localparam int CH_W = $clog2(MAX_CHANNELS);

	logic [MOD_W-1:0] num_modules_q;
	logic [ETA_W-1:0] num_eta_q;
	logic [SUB_W-1:0] num_sub_q;
	logic             calib_q;
	logic             cfg_wr;
	logic [1:0]       reg_idx;
	cadc_cmd_t        cmd;
	cadc_stat_t       stat;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[3:2];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_modules_q <= RST_NUM_MODULES;
			num_eta_q     <= RST_NUM_ETA;
			num_sub_q     <= RST_NUM_SUB;
			calib_q       <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_NUM_MODULES: num_modules_q <= pwdata[MOD_W-1:0];
				REG_NUM_ETA:     num_eta_q     <= pwdata[ETA_W-1:0];
				REG_NUM_SUB:     num_sub_q     <= pwdata[SUB_W-1:0];
				REG_CALIB:       calib_q       <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		case (reg_idx)
			REG_NUM_MODULES: prdata = PDATA_W'(num_modules_q);
			REG_NUM_ETA:     prdata = PDATA_W'(num_eta_q);
			REG_NUM_SUB:     prdata = PDATA_W'(num_sub_q);
			REG_CALIB:       prdata = PDATA_W'(calib_q);
			default:         prdata = '0;
		endcase
	end

	cadc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.calib_present (calib_q),
		.stat          (stat),
		.cmd           (cmd)
	);

	cadc_dp #(
		.MAX_CHANNELS (MAX_CHANNELS),
		.ADC_BITS     (ADC_BITS),
		.CH_W         (CH_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.num_modules  (num_modules_q),
		.num_eta      (num_eta_q),
		.num_sub      (num_sub_q),
		.opcode       (opcode),
		.module_req   (module_req),
		.eta_bin      (eta_bin),
		.sub_bin      (sub_bin),
		.adc          (adc),
		.sim_energy   (sim_energy),
		.pedestal     (pedestal),
		.slope        (slope),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.channel      (channel),
		.energy       (energy),
		.status       (status),
		.hit_count    (hit_count),
		.energy_total (energy_total)
	);

endmodule

// ===== rtl/cadc_chk.sv =====
// port-level checker for the adc calibration block, with its bind
module cadc_chk #(
	parameter int CH_W = 15
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 out_valid,
	input logic                                 out_ready,
	input logic [CH_W-1:0]                      channel,
	input logic [cadc_pkg::ENERGY_W-1:0]        energy,
	input logic [cadc_pkg::STATUS_W-1:0]        status,
	input logic [cadc_pkg::CNT_W-1:0]           hit_count,
	input logic [cadc_pkg::SUM_W-1:0]           energy_total
);
	import cadc_pkg::*;

	// stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(channel) && $stable(energy) &&
			$stable(status) && $stable(hit_count) && $stable(energy_total))
		else $error("result beat changed while stalled");

	// bad slope always reports minus one
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_BAD |-> energy == '1)
		else $error("bad slope without energy of minus one");

	// rejected items carry no channel and no energy
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_RANGE |-> channel == '0 && energy == '0)
		else $error("out of range result with channel or energy");

	// a calibrated hit is positive and has been counted
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_CAL |->
			energy != '0 && !energy[ENERGY_W-1] && hit_count != '0 && energy_total != '0)
		else $error("calibrated hit not counted or not positive");

endmodule

bind calorimeter_adc_calibration cadc_chk #(
	.CH_W ($clog2(MAX_CHANNELS))
) u_cadc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.channel      (channel),
	.energy       (energy),
	.status       (status),
	.hit_count    (hit_count),
	.energy_total (energy_total)
);

// ===== dv/tb_calorimeter_adc_calibration.sv =====
// testbench for the calorimeter adc calibration block with an in-line scoreboard
`timescale 1ns / 1ps

module tb_calorimeter_adc_calibration;
	import cadc_pkg::*;

	localparam int CAL_CHANNELS = 32768;
	localparam int CAL_ADC_BITS = 12;
	localparam int ADC_W = CAL_ADC_BITS + 1;
	localparam int CH_W = $clog2(CAL_CHANNELS);
	localparam int unsigned COUNT_LIMIT = (1 << CNT_W) - 1;
	localparam longint unsigned SUM_LIMIT = (64'd1 << SUM_W) - 1;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// one input beat
	typedef struct packed {
		logic [OP_W-1:0]              op;
		logic [MOD_W-1:0]             module_req;
		logic [ETA_W-1:0]             eta_bin;
		logic [SUB_W-1:0]             sub_bin;
		logic signed [CAL_ADC_BITS:0] adc;
		logic [SIM_W-1:0]             sim_energy;
		logic [PED_W-1:0]             pedestal;
		logic [SLOPE_W-1:0]           slope;
	} hit_beat_t;

	// one result beat
	typedef struct packed {
		logic [CH_W-1:0]            channel;
		logic signed [ENERGY_W-1:0] energy;
		logic [STATUS_W-1:0]        status;
		logic [CNT_W-1:0]           hit_count;
		logic [SUM_W-1:0]           energy_total;
	} calib_out_t;

	class calib_scoreboard;
		// register copies
		int unsigned num_modules = RST_NUM_MODULES;
		int unsigned num_eta = RST_NUM_ETA;
		int unsigned num_sub = RST_NUM_SUB;
		bit calib_on;
		// calibration store and running totals
		logic [PED_W-1:0] ped_mem[int];
		logic [SLOPE_W-1:0] slope_mem[int];
		int unsigned hits;
		longint unsigned esum;
		calib_out_t due_results[$];
		int mismatches;
		int beats;
		int results;
		int status_seen[8];

		function void write_reg(logic [1:0] idx, int unsigned val);
			case (idx)
				REG_NUM_MODULES: num_modules = val & 8'hFF;
				REG_NUM_ETA:     num_eta = val & 8'hFF;
				REG_NUM_SUB:     num_sub = val & 4'hF;
				REG_CALIB:       calib_on = val & 1;
				default: ;
			endcase
		endfunction

		// module/eta/sub to channel number, 0 when out of range
		function bit locate(hit_beat_t b, output int ch);
			longint c;
			ch = 0;
			if (b.module_req == 0 || b.module_req > num_modules || b.eta_bin == 0 ||
			    b.eta_bin > num_eta || b.sub_bin == 0 || b.sub_bin > num_sub)
				return 0;
			c = (longint'(b.module_req) - 1) * num_eta * num_sub +
			    (longint'(b.eta_bin) - 1) * num_sub + (longint'(b.sub_bin) - 1);
			if (c >= CAL_CHANNELS)
				return 0;
			ch = int'(c);
			return 1;
		endfunction

		function void add_to_totals(longint unsigned e);
			if (hits < COUNT_LIMIT)
				hits++;
			esum += e;
			if (esum > SUM_LIMIT)
				esum = SUM_LIMIT;
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: %s", msg);
		endfunction

		// work out the result of an accepted beat and queue it
		function void calibrate_beat(hit_beat_t b);
			calib_out_t want;
			int ch;
			longint num;
			longint q;
			beats++;
			want = '0;
			if (b.op == OP_CLEAR) begin
				hits = 0;
				esum = 0;
				want.status = ST_DONE;
			end else if (b.op == OP_UNUSED || !locate(b, ch)) begin
				want.status = ST_RANGE;
			end else begin
				want.channel = CH_W'(ch);
				if (b.op == OP_LOAD) begin
					ped_mem[ch] = b.pedestal;
					slope_mem[ch] = b.slope;
					want.status = ST_DONE;
				end else if (!calib_on) begin
					// simulated energy only, zero is skipped
					if (b.sim_energy != 0) begin
						add_to_totals(64'(b.sim_energy));
						want.energy = ENERGY_W'(b.sim_energy);
						want.status = ST_SIM;
					end else begin
						want.status = ST_SKIP;
					end
				end else if (b.adc < 0) begin
					// no adc: simulated energy, counted even when zero
					add_to_totals(64'(b.sim_energy));
					want.energy = ENERGY_W'(b.sim_energy);
					want.status = ST_SIM;
				end else if (slope_mem[ch] == 0) begin
					want.energy = '1;
					want.status = ST_BAD;
				end else begin
					num = longint'(b.adc) * 16 - longint'(ped_mem[ch]);
					q = (num > 0) ? (num * 16384) / slope_mem[ch] : 0;
					if (q == 0) begin
						want.status = ST_CLAMP;
					end else begin
						if (q > ENERGY_MAX)
							q = ENERGY_MAX;
						add_to_totals(q);
						want.energy = ENERGY_W'(q);
						want.status = ST_CAL;
					end
				end
			end
			want.hit_count = CNT_W'(hits);
			want.energy_total = SUM_W'(esum);
			due_results.push_back(want);
		endfunction

		// compare a result beat against the oldest expectation
		function void check_beat(calib_out_t got);
			calib_out_t want;
			results++;
			if (due_results.size() == 0) begin
				flag($sformatf("result with nothing pending: ch=%0d e=%0d st=%0d",
					got.channel, got.energy, got.status));
				return;
			end
			want = due_results.pop_front();
			status_seen[want.status]++;
			if (got.channel !== want.channel || got.energy !== want.energy ||
			    got.status !== want.status || got.hit_count !== want.hit_count ||
			    got.energy_total !== want.energy_total)
				flag({$sformatf("#%0d exp ch=%0d e=%0d st=%0d n=%0d sum=%0d",
					results, want.channel, want.energy, want.status, want.hit_count,
					want.energy_total),
					$sformatf(" got ch=%0d e=%0d st=%0d n=%0d sum=%0d",
					got.channel, got.energy, got.status, got.hit_count,
					got.energy_total)});
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] opcode = OP_LOAD;
	logic [MOD_W-1:0] module_req = '0;
	logic [ETA_W-1:0] eta_bin = '0;
	logic [SUB_W-1:0] sub_bin = '0;
	logic signed [CAL_ADC_BITS:0] adc = '0;
	logic [SIM_W-1:0] sim_energy = '0;
	logic [PED_W-1:0] pedestal = '0;
	logic [SLOPE_W-1:0] slope = '0;
	logic out_valid;
	logic out_ready = 1'b1;
	logic [CH_W-1:0] channel;
	logic signed [ENERGY_W-1:0] energy;
	logic [STATUS_W-1:0] status;
	logic [CNT_W-1:0] hit_count;
	logic [SUM_W-1:0] energy_total;

	calib_scoreboard sb = new();
	bit idle_on = 1'b1;
	hit_beat_t slots[$];
	int settings_used = 1;

	calorimeter_adc_calibration #(
		.MAX_CHANNELS(CAL_CHANNELS),
		.ADC_BITS(CAL_ADC_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.module_req(module_req),
		.eta_bin(eta_bin),
		.sub_bin(sub_bin),
		.adc(adc),
		.sim_energy(sim_energy),
		.pedestal(pedestal),
		.slope(slope),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.channel(channel),
		.energy(energy),
		.status(status),
		.hit_count(hit_count),
		.energy_total(energy_total)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side back-pressure in random bursts
	always begin
		@(posedge clk);
		if (idle_on && $urandom_range(0, 11) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
			out_ready <= 1'b1;
		end
	end

	// result beat monitor
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_beat({channel, energy, status, hit_count, energy_total});

	// apb write: setup then access cycle
	task automatic apb_write(logic [1:0] idx, int unsigned val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	// hold off input until every pending result has come out
	task automatic drain();
		if (in_valid)
			in_valid <= 1'b0;
		while (sb.due_results.size() != 0) @(posedge clk);
	endtask

	// one input beat, with an optional gap in front
	task automatic send_beat(hit_beat_t b);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		opcode <= b.op;
		module_req <= b.module_req;
		eta_bin <= b.eta_bin;
		sub_bin <= b.sub_bin;
		adc <= b.adc;
		sim_energy <= b.sim_energy;
		pedestal <= b.pedestal;
		slope <= b.slope;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.calibrate_beat(b);
	endtask

	function automatic hit_beat_t beat(logic [OP_W-1:0] op, int m, int e, int s, int a,
		int sim, int ped, int slp);
		hit_beat_t b;
		b.op = op;
		b.module_req = MOD_W'(m);
		b.eta_bin = ETA_W'(e);
		b.sub_bin = SUB_W'(s);
		b.adc = ADC_W'(a);
		b.sim_energy = SIM_W'(sim);
		b.pedestal = PED_W'(ped);
		b.slope = SLOPE_W'(slp);
		return b;
	endfunction

	// bin index biased toward both ends of its range
	function automatic int pick_bin(int unsigned top);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 1;
		if (r == 1)
			return top;
		return $urandom_range(1, top);
	endfunction

	function automatic hit_beat_t random_beat(bit load_only);
		hit_beat_t b;
		int pick;
		int ch;
		pick = $urandom_range(0, 99);
		if (load_only || pick < 22)
			b.op = OP_LOAD;
		else if (pick < 92)
			b.op = OP_HIT;
		else if (pick < 96)
			b.op = OP_CLEAR;
		else
			b.op = OP_UNUSED;
		// address: mostly inside the layout, sometimes anywhere
		if ($urandom_range(0, 6) == 0) begin
			b.module_req = MOD_W'($urandom);
			b.eta_bin = ETA_W'($urandom);
			b.sub_bin = SUB_W'($urandom);
		end else begin
			b.module_req = MOD_W'(pick_bin(sb.num_modules));
			b.eta_bin = ETA_W'(pick_bin(sb.num_eta));
			b.sub_bin = SUB_W'(pick_bin(sb.num_sub));
		end
		pick = $urandom_range(0, 19);
		if (pick == 0)
			b.adc = ADC_W'(-2);
		else if (pick < 3)
			b.adc = ADC_W'(-1);
		else if (pick == 3)
			b.adc = ADC_W'(4095);
		else if (pick == 4)
			b.adc = '0;
		else
			b.adc = ADC_W'($urandom_range(0, 4095));
		pick = $urandom_range(0, 19);
		b.sim_energy = (pick == 0) ? 24'd0 : (pick == 1) ? 24'hFFFFFF : SIM_W'($urandom);
		pick = $urandom_range(0, 9);
		b.pedestal = (pick < 5) ? PED_W'($urandom_range(0, 1500)) :
			(pick == 5) ? 16'hFFFF : PED_W'($urandom);
		pick = $urandom_range(0, 19);
		if (pick < 2)
			b.slope = '0;
		else if (pick < 5)
			b.slope = SLOPE_W'($urandom_range(1, 63));
		else if (pick == 5)
			b.slope = 24'hFFFFFF;
		else if (pick == 6)
			b.slope = SLOPE_W'($urandom_range(1 << 20, 24'hFFFFFF));
		else
			b.slope = SLOPE_W'($urandom_range(256, 1 << 18));
		// calibrated hits only go to channels that hold a calibration
		if (b.op == OP_HIT && sb.calib_on && !b.adc[CAL_ADC_BITS] && sb.locate(b, ch) &&
		    !sb.ped_mem.exists(ch)) begin
			if (slots.size() != 0) begin
				pick = $urandom_range(0, slots.size() - 1);
				b.module_req = slots[pick].module_req;
				b.eta_bin = slots[pick].eta_bin;
				b.sub_bin = slots[pick].sub_bin;
			end else begin
				b.adc = ADC_W'(-1);
			end
		end
		return b;
	endfunction

	// new register setting, then a stretch of random beats
	task automatic run_phase(int mods, int etas, int subs, int cal, int count);
		hit_beat_t b;
		int ch;
		drain();
		apb_write(REG_NUM_MODULES, mods);
		apb_write(REG_NUM_ETA, etas);
		apb_write(REG_NUM_SUB, subs);
		apb_write(REG_CALIB, cal);
		settings_used++;
		slots.delete();
		for (int i = 0; i < count; i++) begin
			b = random_beat(i < 10);
			if (b.op == OP_LOAD && sb.locate(b, ch))
				slots.push_back(b);
			send_beat(b);
			if ($urandom_range(0, 59) == 0)
				drain();
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: loads and hits under the reset layout, no calibration
		send_beat(beat(OP_LOAD, 1, 1, 1, 0, 0, 0, 1));
		send_beat(beat(OP_LOAD, 120, 20, 2, 4095, 0, 16'hFFFF, 24'hFFFFFF));
		send_beat(beat(OP_LOAD, 2, 1, 1, 0, 0, 100, 0));
		send_beat(beat(OP_LOAD, 3, 5, 2, 0, 0, 40000, 1000));
		send_beat(beat(OP_LOAD, 4, 1, 1, 0, 0, 0, 24'hFFFFFF));
		send_beat(beat(OP_LOAD, 5, 1, 1, 0, 0, 160, 4096));
		send_beat(beat(OP_HIT, 1, 1, 1, 100, 0, 0, 0));
		send_beat(beat(OP_HIT, 1, 1, 1, 100, 24'hFFFFFF, 0, 0));
		send_beat(beat(OP_HIT, 0, 1, 1, 100, 5, 0, 0));
		send_beat(beat(OP_HIT, 121, 1, 1, 100, 5, 0, 0));
		send_beat(beat(OP_HIT, 1, 0, 1, 100, 5, 0, 0));
		send_beat(beat(OP_HIT, 255, 21, 1, 100, 5, 0, 0));
		send_beat(beat(OP_HIT, 1, 1, 0, 100, 5, 0, 0));
		send_beat(beat(OP_LOAD, 1, 1, 15, 0, 0, 7, 7));
		send_beat(beat(OP_UNUSED, 255, 255, 15, -1, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF));
		send_beat(beat(OP_CLEAR, 1, 1, 1, 0, 0, 0, 0));

		// directed: calibrated path on the channels loaded above
		drain();
		apb_write(REG_CALIB, 1);
		settings_used++;
		send_beat(beat(OP_HIT, 1, 1, 1, 4095, 0, 0, 0));
		send_beat(beat(OP_HIT, 2, 1, 1, 10, 0, 0, 0));
		send_beat(beat(OP_HIT, 3, 5, 2, 100, 0, 0, 0));
		send_beat(beat(OP_HIT, 4, 1, 1, 1, 0, 0, 0));
		send_beat(beat(OP_HIT, 5, 1, 1, 0, 0, 0, 0));
		send_beat(beat(OP_HIT, 5, 1, 1, 200, 0, 0, 0));
		send_beat(beat(OP_HIT, 1, 1, 1, -1, 0, 0, 0));
		send_beat(beat(OP_HIT, 120, 20, 2, -2, 24'hFFFFFF, 0, 0));
		send_beat(beat(OP_HIT, 120, 20, 2, 4095, 0, 0, 0));

		// random stretches across layouts, extremes first
		run_phase(120, 20, 2, 1, 105);
		run_phase(1, 1, 1, 1, 105);
		run_phase(255, 255, 15, 1, 105);
		run_phase(255, 255, 15, 0, 105);
		run_phase(8, 4, 3, 1, 105);
		run_phase(1, 255, 1, 0, 105);
		run_phase(255, 1, 15, 1, 105);
		repeat (2)
			run_phase($urandom_range(1, 255), $urandom_range(1, 255), $urandom_range(1, 15),
				$urandom_range(0, 1), 105);

		// back to back full-scale hits with no idling
		idle_on = 1'b0;
		run_phase(1, 1, 1, 0, 0);
		send_beat(beat(OP_CLEAR, 1, 1, 1, 0, 0, 0, 0));
		repeat (20)
			send_beat(beat(OP_HIT, 1, 1, 1, $urandom_range(0, 4095), 24'hFFFFFF,
				$urandom, $urandom));
		send_beat(beat(OP_CLEAR, 1, 1, 1, 0, 0, 0, 0));

		run_phase(16, 16, 8, 1, 60);

		drain();
		repeat (40) @(posedge clk);
		$display("covered %0d input beats, %0d result beats, %0d register settings",
			sb.beats, sb.results, settings_used);
		$display("status mix: cal %0d clamp %0d bad %0d sim %0d skip %0d range %0d done %0d",
			sb.status_seen[ST_CAL], sb.status_seen[ST_CLAMP], sb.status_seen[ST_BAD],
			sb.status_seen[ST_SIM], sb.status_seen[ST_SKIP], sb.status_seen[ST_RANGE],
			sb.status_seen[ST_DONE]);
		if (sb.mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// watchdog
	initial begin
		#30_000_000;
		$display("timeout with %0d results pending", sb.due_results.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
